/* hdl/mop_pkg.sv */
// shared types, constants and key functions of the morton order permutation block
`timescale 1ns / 1ps
package mop_pkg;

	localparam int MaxPointsDef = 64;
	localparam int AxisBits     = 10;
	localparam int KeyBits      = 3 * AxisBits;
	localparam int CoordBits    = 32;
	localparam int QueueDepth   = 8;
	localparam int CfgIdxBits   = 3;

	// configuration register indexes
	localparam logic [CfgIdxBits-1:0] REG_MIN_X   = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_MIN_Y   = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_MIN_Z   = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_SCALE_X = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_SCALE_Y = 3'd4;
	localparam logic [CfgIdxBits-1:0] REG_SCALE_Z = 3'd5;

	localparam logic [31:0] MASK_S16 = 32'h030000FF;
	localparam logic [31:0] MASK_S8  = 32'h0300F00F;
	localparam logic [31:0] MASK_S4  = 32'h030C30C3;
	localparam logic [31:0] MASK_S2  = 32'h09249249;
	localparam logic [AxisBits-1:0] AXIS_MAX = AxisBits'((1 << AxisBits) - 1);

	// one queue entry: key of a point and its end-of-set mark
	typedef struct packed {
		logic [KeyBits-1:0] key;
		logic               last;
	} qent_t;

	// (a + (b >> 16)) >> 16 saturated to the axis range
	function automatic logic [AxisBits-1:0] quant_sat(input logic [48:0] a, input logic [48:0] b);
		logic [49:0] s;
		s = {1'b0, a} + {17'b0, b[48:16]};
		if (|s[49:16+AxisBits])
			return AXIS_MAX;
		return s[16+AxisBits-1:16];
	endfunction

	// spread the bits of an axis value three apart
	function automatic logic [31:0] spread(input logic [AxisBits-1:0] v);
		logic [31:0] w;
		w = {22'b0, v};
		w = (w | (w << 16)) & MASK_S16;
		w = (w | (w << 8)) & MASK_S8;
		w = (w | (w << 4)) & MASK_S4;
		w = (w | (w << 2)) & MASK_S2;
		return w;
	endfunction

	function automatic logic [KeyBits-1:0] interleave(input logic [AxisBits-1:0] x,
		input logic [AxisBits-1:0] y, input logic [AxisBits-1:0] z);
		logic [31:0] k;
		k = spread(x) | (spread(y) << 1) | (spread(z) << 2);
		return k[KeyBits-1:0];
	endfunction

endpackage

/* hdl/morton_order_permutation.sv */
// top level of the morton order permutation block
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata x,y,z; tlast last_point
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata pos,perm,rank,key; tuser overflow
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// points are taken one per cycle while s_axis_tready is high; each beat passes a quantize
// pipeline into an eight-entry queue; the loading back end stores one key per cycle.
// after the last point the rank-counting sort ranks each point against all keys through
// the key store's single read port; each result is then read out before it is offered.
// reset initialises control state and configuration registers; stores need no clearing.
// a stalled result holds; loading of the next set continues into the queue meanwhile.
`timescale 1ns / 1ps
module morton_order_permutation import mop_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxBits-1:0]  cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [95:0]            s_axis_tdata,  // coord_x, coord_y, coord_z
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [55:0]            m_axis_tdata,  // position, perm_index, rank_index, morton_key
	output logic                   m_axis_tlast,
	output logic                   m_axis_tuser   // overflow
);

	qent_t push_ent, head;
	logic  push, pop, q_ne;
	logic [$clog2(QueueDepth+1)-1:0] level;
	logic [5:0]         position;
	logic [6:0]         perm, rank;
	logic [KeyBits-1:0] key;

	assign cfg_ready = 1'b1;

	// quantize front end
	mop_front #(.QDEPTH(QueueDepth)) u_front (
		.clk, .arst_n,
		.cfg_valid, .cfg_index, .cfg_data,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_last(s_axis_tlast),
		.q_level(level), .push, .push_ent
	);

	// decoupling queue
	mop_queue #(.DEPTH(QueueDepth)) u_queue (
		.clk, .arst_n, .push, .push_ent, .pop,
		.not_empty(q_ne), .head, .level
	);

	// sort and emit
	mop_back #(.MAX_POINTS(MAX_POINTS)) u_back (
		.clk, .arst_n,
		.q_valid(q_ne), .q_head(head), .q_pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_position(position), .out_perm(perm), .out_rank(rank), .out_key(key),
		.out_overflow(m_axis_tuser), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, key, rank, perm, position};

endmodule

/* hdl/mop_front.sv */
// front end: configuration registers and the quantize and interleave pipeline
`timescale 1ns / 1ps
module mop_front import mop_pkg::*; #(
	parameter int QDEPTH = QueueDepth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CfgIdxBits-1:0]  cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [3*CoordBits-1:0] in_data,
	input  logic                   in_last,
	input  logic [$clog2(QDEPTH+1)-1:0] q_level,
	output logic                   push,
	output qent_t                  push_ent
);

	logic [31:0] min_q [3];
	logic [31:0] scale_q [3];
	logic        v_s1, v_s2, last_s1, last_s2;
	logic [33:0] diff_s1 [3];
	logic [48:0] hi_s2 [3];
	logic [48:0] lo_s2 [3];
	logic [AxisBits-1:0] qv [3];
	logic        accept;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a]   <= 32'd0;
				scale_q[a] <= 32'd65536;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_X:   min_q[0]   <= cfg_data;
				REG_MIN_Y:   min_q[1]   <= cfg_data;
				REG_MIN_Z:   min_q[2]   <= cfg_data;
				REG_SCALE_X: scale_q[0] <= cfg_data;
				REG_SCALE_Y: scale_q[1] <= cfg_data;
				REG_SCALE_Z: scale_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// room in the queue for everything in flight plus one more beat
	assign in_ready = (32'(q_level) + 32'(v_s1) + 32'(v_s2)) < QDEPTH;
	assign accept   = in_valid && in_ready;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// stage 1: signed offset, stage 2: two partial products per axis
	always_ff @(posedge clk) begin
		last_s1 <= in_last;
		last_s2 <= last_s1;
		for (int a = 0; a < 3; a++) begin
			diff_s1[a] <= {{2{in_data[CoordBits*a+31]}}, in_data[CoordBits*a +: 32]}
				- {{2{min_q[a][31]}}, min_q[a]};
			hi_s2[a] <= 49'(diff_s1[a][33] ? 33'd0 : diff_s1[a][32:0])
				* 49'(scale_q[a][31:16]);
			lo_s2[a] <= 49'(diff_s1[a][33] ? 33'd0 : diff_s1[a][32:0])
				* 49'(scale_q[a][15:0]);
		end
	end

	// saturate and interleave into the queue
	always_comb begin
		for (int a = 0; a < 3; a++)
			qv[a] = quant_sat(hi_s2[a], lo_s2[a]);
	end

	assign push          = v_s2;
	assign push_ent.key  = interleave(qv[0], qv[1], qv[2]);
	assign push_ent.last = last_s2;

endmodule

/* hdl/mop_queue.sv */
// short queue of keyed points between front and back
`timescale 1ns / 1ps
module mop_queue import mop_pkg::*; #(
	parameter int DEPTH = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_ent,
	input  logic  pop,
	output logic  not_empty,
	output qent_t head,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);

	qent_t            mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic             do_pop;

	assign not_empty = cnt_q != '0;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];
	assign level     = cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_ent;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* hdl/mop_back.sv */
// back end: key store, rank-counting sort and result emission
`timescale 1ns / 1ps
module mop_back import mop_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDef
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  qent_t q_head,
	output logic  q_pop,
	output logic  out_valid,
	input  logic  out_ready,
	output logic [5:0]         out_position,
	output logic [6:0]         out_perm,
	output logic [6:0]         out_rank,
	output logic [KeyBits-1:0] out_key,
	output logic               out_overflow,
	output logic               out_last
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_LDI   = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_EMRD  = 3'd3;
	localparam logic [2:0] ST_EMOUT = 3'd4;

	logic [KeyBits-1:0] key_mem  [MAX_POINTS];
	logic [KeyBits-1:0] skey_mem [MAX_POINTS];
	logic [IW-1:0]      rank_mem [MAX_POINTS];
	logic [IW-1:0]      perm_mem [MAX_POINTS];

	logic [2:0]         state_q;
	logic [CW-1:0]      count_q, i_q, j_q, p_q;
	logic               drop_q;
	logic [IW-1:0]      cnt_q;
	logic [KeyBits-1:0] ki_q, key_rd_q, skey_rd_q;
	logic [IW-1:0]      rank_rd_q, perm_rd_q;
	logic [IW-1:0]      key_addr;
	logic [CW-1:0]      jm1;
	logic               hit, full, last_cmp, wr_sort;
	logic [IW-1:0]      cnt_nx;

	assign full     = count_q == CW'(MAX_POINTS);
	assign q_pop    = (state_q == ST_LOAD) && q_valid;
	assign jm1      = j_q - 1'b1;
	assign hit      = (key_rd_q < ki_q) || ((key_rd_q == ki_q) && (jm1 < i_q));
	assign last_cmp = (state_q == ST_CMP) && (j_q == count_q);
	assign cnt_nx   = cnt_q + IW'(hit);
	assign wr_sort  = last_cmp;
	assign key_addr = (state_q == ST_LDI) ? i_q[IW-1:0] : j_q[IW-1:0];

	// key store: loaded points, read during the sort
	always_ff @(posedge clk) begin
		if (q_pop && !full)
			key_mem[count_q[IW-1:0]] <= q_head.key;
		key_rd_q <= key_mem[key_addr];
	end

	// sorted outputs written once per point, read at the emitted position
	always_ff @(posedge clk) begin
		if (wr_sort) begin
			rank_mem[i_q[IW-1:0]] <= cnt_nx;
			perm_mem[cnt_nx]      <= i_q[IW-1:0];
			skey_mem[cnt_nx]      <= ki_q;
		end
		rank_rd_q <= rank_mem[p_q[IW-1:0]];
		perm_rd_q <= perm_mem[p_q[IW-1:0]];
		skey_rd_q <= skey_mem[p_q[IW-1:0]];
	end

	// key of the point being ranked is the first read of each pass
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && j_q == '0)
			ki_q <= key_rd_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (full)
							drop_q <= 1'b1;
						else
							count_q <= count_q + 1'b1;
						if (q_head.last) begin
							i_q     <= '0;
							state_q <= ST_LDI;
						end
					end
				end
				ST_LDI: begin
					j_q     <= '0;
					cnt_q   <= '0;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					j_q <= j_q + 1'b1;
					if (j_q != '0)
						cnt_q <= cnt_nx;
					if (last_cmp) begin
						i_q <= i_q + 1'b1;
						if (i_q + 1'b1 == count_q) begin
							p_q     <= '0;
							state_q <= ST_EMRD;
						end else begin
							state_q <= ST_LDI;
						end
					end
				end
				ST_EMRD: state_q <= ST_EMOUT;
				ST_EMOUT: begin
					if (out_ready) begin
						if (out_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							p_q     <= p_q + 1'b1;
							state_q <= ST_EMRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// result beat
	assign out_valid    = state_q == ST_EMOUT;
	assign out_position = 6'(p_q);
	assign out_perm     = 7'(perm_rd_q) + 7'd1;
	assign out_rank     = 7'(rank_rd_q) + 7'd1;
	assign out_key      = skey_rd_q;
	assign out_overflow = drop_q;
	assign out_last     = (p_q + 1'b1) == count_q;

endmodule

/* hdl/mop_checker.sv */
// port-level checks of the morton order permutation block and their bind
`timescale 1ns / 1ps
module mop_checker import mop_pkg::*; #(
	parameter int MAX_POINTS = MaxPointsDef
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_ready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// one-based point index within capacity
	a_perm: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[12:6] != 7'd0 && 32'(m_axis_tdata[12:6]) <= MAX_POINTS)
		else $error("perm index out of range");

	// one-based rank within capacity
	a_rank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[19:13] != 7'd0 && 32'(m_axis_tdata[19:13]) <= MAX_POINTS)
		else $error("rank index out of range");

	// position after a non-final beat steps by one
	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid ##1
			(m_axis_tvalid && m_axis_tdata[5:0] == $past(m_axis_tdata[5:0], 2) + 6'd1))
		else $error("position sequence broken");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind morton_order_permutation mop_checker #(.MAX_POINTS(MAX_POINTS)) u_mop_checker (
	.clk, .arst_n, .cfg_ready, .m_axis_tvalid, .m_axis_tready,
	.m_axis_tdata, .m_axis_tlast, .m_axis_tuser
);

/* bench/tb_morton_order_permutation.sv */
// morton order permutation testbench: directed and random point sets checked against a key sort model
`timescale 1ns / 1ps
module tb_morton_order_permutation;
	import mop_pkg::*;

	localparam int NPTS = 64;

	// expected result of one sorted position
	typedef struct {
		logic [5:0]  pos;
		logic [6:0]  perm;
		logic [6:0]  rank;
		logic [29:0] key;
		logic        ovf;
		logic        last;
	} sorted_slot_t;

	// keeps the sort model state and the queue of expected slots
	class morton_sort_board;
		logic [31:0] lo[3];
		logic [31:0] scl[3];
		logic [29:0] keys[NPTS];
		int          count;
		bit          dropped;
		sorted_slot_t pending[$];
		int          errors;
		int          checked;

		function new();
			foreach (lo[i]) begin
				lo[i] = 0;
				scl[i] = 32'h10000;
			end
			count = 0;
			dropped = 0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [9:0] quantize_axis(logic [31:0] c, logic [31:0] l, logic [31:0] s);
			longint diff;
			logic [63:0] d, a, b, q;
			diff = longint'($signed(c)) - longint'($signed(l));
			if (diff <= 0)
				return 10'd0;
			d = diff;
			a = d * s[31:16];
			b = d * s[15:0];
			q = (a + (b >> 16)) >> 16;
			return (q > 1023) ? 10'd1023 : q[9:0];
		endfunction

		function logic [29:0] interleave_key(logic [9:0] x, logic [9:0] y, logic [9:0] z);
			logic [29:0] k;
			k = '0;
			for (int i = 0; i < 10; i++) begin
				k[3*i] = x[i];
				k[3*i+1] = y[i];
				k[3*i+2] = z[i];
			end
			return k;
		endfunction

		// load one point; on the set end, sort and queue the slots
		function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit lp);
			int order[NPTS];
			int rnk[NPTS];
			int j, cur;
			sorted_slot_t s;
			if (count < NPTS) begin
				keys[count] = interleave_key(quantize_axis(x, lo[0], scl[0]),
					quantize_axis(y, lo[1], scl[1]), quantize_axis(z, lo[2], scl[2]));
				count++;
			end else
				dropped = 1;
			if (!lp)
				return;
			for (int i = 0; i < count; i++) begin
				cur = i;
				j = i;
				while (j > 0 && keys[order[j-1]] > keys[cur]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = cur;
			end
			for (int i = 0; i < count; i++)
				rnk[order[i]] = i;
			for (int p = 0; p < count; p++) begin
				s.pos = 6'(p);
				s.perm = 7'(order[p] + 1);
				s.rank = 7'(rnk[p] + 1);
				s.key = keys[order[p]];
				s.ovf = dropped;
				s.last = (p + 1 == count);
				pending.push_back(s);
			end
			count = 0;
			dropped = 0;
		endfunction

		task report_mismatch(string what, longint got, longint want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
		endtask

		task check_slot(sorted_slot_t got);
			sorted_slot_t e;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("result beat with nothing expected", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (got.pos != e.pos) report_mismatch("position", got.pos, e.pos);
			if (got.perm != e.perm) report_mismatch("perm_index", got.perm, e.perm);
			if (got.rank != e.rank) report_mismatch("rank_index", got.rank, e.rank);
			if (got.key != e.key) report_mismatch("morton_key", got.key, e.key);
			if (got.ovf != e.ovf) report_mismatch("overflow", got.ovf, e.ovf);
			if (got.last != e.last) report_mismatch("last_result", got.last, e.last);
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	morton_sort_board board = new();
	longint cycles = 0;
	int     points_sent = 0;
	int     sets_sent = 0;
	bit     sink_busy_off = 0;

	morton_order_permutation i_dut (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("timeout");
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, check each accepted beat
	initial begin
		int gap;
		sorted_slot_t got;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.pos = m_axis_tdata[5:0];
				got.perm = m_axis_tdata[12:6];
				got.rank = m_axis_tdata[19:13];
				got.key = m_axis_tdata[49:20];
				got.ovf = m_axis_tuser;
				got.last = m_axis_tlast;
				board.check_slot(got);
				gap = sink_busy_off ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
				if (gap > 0) begin
					m_axis_tready <= 0;
					repeat (gap) @(posedge clk);
				end
				m_axis_tready <= 1;
			end else if (!m_axis_tready)
				m_axis_tready <= 1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
		board.lo[0] = board.lo[0];
		case (idx)
			REG_MIN_X: board.lo[0] = val;
			REG_MIN_Y: board.lo[1] = val;
			REG_MIN_Z: board.lo[2] = val;
			REG_SCALE_X: board.scl[0] = val;
			REG_SCALE_Y: board.scl[1] = val;
			REG_SCALE_Z: board.scl[2] = val;
			default: ;
		endcase
	endtask

	// valid drops only for an idle gap, so beats can follow back to back
	task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
		input bit lp, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12));
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x};
		s_axis_tlast <= lp;
		do @(posedge clk); while (!s_axis_tready);
		board.note_point(x, y, z, lp);
		points_sent++;
		if (lp) sets_sent++;
	endtask

	// wait for every expected slot, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 32'h3FF_FFFF);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_set(input int n, input bit dense);
		for (int i = 0; i < n; i++)
			send_point(rand_coord(), rand_coord(),
				dense ? $urandom_range(0, 3) << 16 : rand_coord(), i == n - 1, 0);
	endtask

	initial begin
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes under reset settings, equal keys, saturation, below minimum
		send_point(32'h0, 32'h0, 32'h0, 0, 1);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1);
		send_point(32'h0, 32'h0, 32'h0, 0, 1);
		send_point(32'h0003_0000, 32'h0001_8000, 32'h03FF_0000, 1, 1);
		// single point set
		send_point(32'h0005_0000, 32'h0, 32'h0, 1, 0);
		drain();

		// extreme registers
		write_reg(REG_MIN_X, 32'h8000_0000);
		write_reg(REG_MIN_Y, 32'h7FFF_FFFF);
		write_reg(REG_MIN_Z, 32'hFFFF_0000);
		write_reg(REG_SCALE_X, 32'hFFFF_FFFF);
		write_reg(REG_SCALE_Y, 32'h0);
		write_reg(REG_SCALE_Z, 32'h0000_0001);
		send_point(32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 0, 1);
		send_point(32'h8000_0000, 32'h0, 32'h0, 1, 1);
		drain();

		// full set plus dropped points, last one dropped too
		write_reg(REG_MIN_X, 32'h0);
		write_reg(REG_MIN_Y, 32'h0);
		write_reg(REG_MIN_Z, 32'h0);
		write_reg(REG_SCALE_X, 32'h0001_0000);
		write_reg(REG_SCALE_Y, 32'h0001_0000);
		write_reg(REG_SCALE_Z, 32'h0001_0000);
		random_set(NPTS + 3, 1);
		drain();

		// random phases with fresh settings between
		while (points_sent < 460) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				for (int r = 0; r < 6; r++)
					write_reg(r[2:0], $urandom_range(0, 1) ? $urandom : (r < 3 ? $urandom_range(0, 32'h3FF_FFFF)
						: $urandom_range(32'h100, 32'h40_0000)));
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, NPTS + 2) : $urandom_range(1, 12);
			random_set(n, $urandom_range(0, 3) == 0);
		end
		// a stretch with the sink never stalling
		drain();
		sink_busy_off = 1;
		random_set(20, 0);
		drain();

		$display("covered %0d points in %0d sets, %0d result beats checked",
			points_sent, sets_sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* morton_order_permutation.f */
hdl/mop_pkg.sv
hdl/mop_front.sv
hdl/mop_queue.sv
hdl/mop_back.sv
hdl/morton_order_permutation.sv
hdl/mop_checker.sv
bench/tb_morton_order_permutation.sv
